[hw/rtl/biq_pkg.sv]
package biq_pkg;

    // Fixed-point format shared by all blocks of the section.
    localparam int FRAC_BITS       = 28;
    localparam int COEF_WIDTH      = 32;
    localparam int WIDE_WIDTH      = 64;
    localparam int CHUNK_WIDTH     = 32;
    localparam int MUL_B_WIDTH     = CHUNK_WIDTH + 1;
    localparam int PROD_WIDTH      = COEF_WIDTH + MUL_B_WIDTH;
    localparam int FULL_WIDTH      = PROD_WIDTH + CHUNK_WIDTH;
    localparam int SHIFTED_WIDTH   = FULL_WIDTH - FRAC_BITS;
    localparam int OUT_SHIFT_WIDTH = WIDE_WIDTH - FRAC_BITS;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_FORM    = 3'd1,
        CFG_COEF_B0 = 3'd2,
        CFG_COEF_B1 = 3'd3,
        CFG_COEF_B2 = 3'd4,
        CFG_COEF_A1 = 3'd5,
        CFG_COEF_A2 = 3'd6
    } cfg_index_t;

    localparam logic FORM_DF1 = 1'b0;
    localparam logic FORM_TF2 = 1'b1;

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = 32'h1000_0000;

    // Sequencer step counter.
    localparam int STEP_WIDTH = 5;
    localparam logic [STEP_WIDTH-1:0] LAST_STEP_DF1 = 5'd12;
    localparam logic [STEP_WIDTH-1:0] LAST_STEP_TF2 = 5'd16;

    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic [2:0] {
        VAL_XQ  = 3'd0,
        VAL_D1  = 3'd1,
        VAL_D2  = 3'd2,
        VAL_OD1 = 3'd3,
        VAL_OD2 = 3'd4,
        VAL_Y   = 3'd5
    } val_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        SRC_TERM = 2'd0,
        SRC_D1   = 2'd1,
        SRC_D2   = 2'd2
    } acc_src_t;

    typedef enum logic [2:0] {
        WR_NONE    = 3'd0,
        WR_Y       = 3'd1,
        WR_Y_SHIFT = 3'd2,
        WR_D1      = 3'd3,
        WR_D2      = 3'd4
    } wr_sel_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_set_t;

    // One cycle of datapath control issued by the sequencer.
    typedef struct packed {
        logic      load_sample;
        logic      start;
        logic      mul_en;
        logic      mul_hi;
        coef_sel_t coef_sel;
        val_sel_t  val_sel;
        acc_op_t   acc_op;
        acc_src_t  acc_src;
        wr_sel_t   wr_sel;
        logic      out_load;
        logic      bypass;
    } dp_cmd_t;

endpackage

[hw/rtl/biq_ctrl.sv]
module biq_ctrl
    import biq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    enable,
    input  logic    form_select,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STEP_WIDTH-1:0] last_step;

    // Operation schedule of one filtered word. A product, issued low half first, passes through
    // mul_reg, lo_reg and term_reg on its way to the accumulator.
    function automatic dp_cmd_t step_cmd(input logic form, input logic [STEP_WIDTH-1:0] step);
        dp_cmd_t c;
        c = '0;
        if (form == FORM_DF1)
        begin
            unique case (step)
                5'd0:  begin c.start = 1'b1; c.mul_en = 1'b1;
                             c.coef_sel = COEF_B0; c.val_sel = VAL_XQ; end
                5'd1:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B0; c.val_sel = VAL_XQ; end
                5'd2:  begin c.mul_en = 1'b1; c.coef_sel = COEF_B1; c.val_sel = VAL_D1; end
                5'd3:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B1; c.val_sel = VAL_D1;
                             c.acc_op = ACC_LOAD; end
                5'd4:  begin c.mul_en = 1'b1; c.coef_sel = COEF_B2; c.val_sel = VAL_D2; end
                5'd5:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B2; c.val_sel = VAL_D2;
                             c.acc_op = ACC_ADD; end
                5'd6:  begin c.mul_en = 1'b1; c.coef_sel = COEF_A1; c.val_sel = VAL_OD1; end
                5'd7:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_A1; c.val_sel = VAL_OD1;
                             c.acc_op = ACC_ADD; end
                5'd8:  begin c.mul_en = 1'b1; c.coef_sel = COEF_A2; c.val_sel = VAL_OD2; end
                5'd9:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_A2; c.val_sel = VAL_OD2;
                             c.acc_op = ACC_SUB; end
                5'd11: begin c.acc_op = ACC_SUB; end
                5'd12: begin c.wr_sel = WR_Y_SHIFT; end
                default: ;
            endcase
        end
        else
        begin
            unique case (step)
                5'd0:  begin c.start = 1'b1; c.mul_en = 1'b1;
                             c.coef_sel = COEF_B0; c.val_sel = VAL_XQ; end
                5'd1:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B0; c.val_sel = VAL_XQ; end
                5'd2:  begin c.mul_en = 1'b1; c.coef_sel = COEF_B1; c.val_sel = VAL_XQ; end
                5'd3:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B1; c.val_sel = VAL_XQ;
                             c.acc_op = ACC_LOAD; end
                5'd4:  begin c.acc_op = ACC_ADD; c.acc_src = SRC_D1; end
                5'd5:  begin c.acc_op = ACC_LOAD; c.wr_sel = WR_Y; end
                5'd6:  begin c.mul_en = 1'b1; c.coef_sel = COEF_A1; c.val_sel = VAL_Y; end
                5'd7:  begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_A1; c.val_sel = VAL_Y; end
                5'd9:  begin c.acc_op = ACC_SUB; end
                5'd10: begin c.acc_op = ACC_ADD; c.acc_src = SRC_D2;
                             c.mul_en = 1'b1; c.coef_sel = COEF_B2; c.val_sel = VAL_XQ; end
                5'd11: begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_B2; c.val_sel = VAL_XQ;
                             c.wr_sel = WR_D1; end
                5'd12: begin c.mul_en = 1'b1; c.coef_sel = COEF_A2; c.val_sel = VAL_Y; end
                5'd13: begin c.mul_en = 1'b1; c.mul_hi = 1'b1;
                             c.coef_sel = COEF_A2; c.val_sel = VAL_Y;
                             c.acc_op = ACC_LOAD; end
                5'd15: begin c.acc_op = ACC_SUB; end
                5'd16: begin c.wr_sel = WR_D2; end
                default: ;
            endcase
        end
        return c;
    endfunction

    assign last_step = (form_select == FORM_TF2) ? LAST_STEP_TF2 : LAST_STEP_DF1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    step_next       = '0;
                    state_next      = enable ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                cmd = step_cmd(form_select, step_reg);
                if (step_reg == last_step)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // Hand the word to the output register once its slot is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.bypass     = ~enable;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while a word is waiting");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after taking a word");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= last_step))
        else $error("step counter ran past the schedule");

    a_load_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FINISH) |-> !cmd.out_load)
        else $error("output loaded outside the finish state");
`endif

endmodule

[hw/rtl/biq_datapath.sv]
module biq_datapath
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  coef_set_t               coef,
    input  dp_cmd_t                 cmd,
    input  logic [SAMPLE_WIDTH-1:0] sample_in,
    output logic [SAMPLE_WIDTH-1:0] sample_out,
    output logic                    clipped
);

    localparam logic [PROD_WIDTH-1:0] ROUND_PROD = PROD_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic [WIDE_WIDTH:0]   ROUND_WIDE = (WIDE_WIDTH + 1)'(1) << (FRAC_BITS - 1);

    logic signed [SAMPLE_WIDTH-1:0]  sample_reg;
    logic signed [STATE_WIDTH-1:0]   d1_reg;
    logic signed [STATE_WIDTH-1:0]   d2_reg;
    logic signed [STATE_WIDTH-1:0]   od1_reg;
    logic signed [STATE_WIDTH-1:0]   od2_reg;
    logic signed [STATE_WIDTH-1:0]   y_reg;
    logic signed [PROD_WIDTH-1:0]    mul_reg;
    logic                            mul_vld_reg;
    logic                            mul_hi_reg;
    logic signed [PROD_WIDTH-1:0]    lo_reg;
    logic signed [WIDE_WIDTH-1:0]    term_reg;
    logic signed [WIDE_WIDTH-1:0]    acc_reg;
    logic                            sat_reg;
    logic [SAMPLE_WIDTH-1:0]         out_sample_reg;
    logic                            out_clip_reg;

    logic signed [WIDE_WIDTH-1:0]    x_wide;
    logic [STATE_WIDTH:0]            xq_clamp;
    logic signed [COEF_WIDTH-1:0]    coef_op;
    logic signed [STATE_WIDTH-1:0]   val_op;
    logic signed [WIDE_WIDTH-1:0]    val_wide;
    logic signed [MUL_B_WIDTH-1:0]   mul_b;
    logic signed [PROD_WIDTH-1:0]    mul_prod;
    logic signed [FULL_WIDTH-1:0]    full_prod;
    logic [SHIFTED_WIDTH-1:0]        prod_shift;
    logic                            term_ovf;
    logic [WIDE_WIDTH-1:0]           term_next;
    logic signed [WIDE_WIDTH-1:0]    acc_opnd;
    logic signed [WIDE_WIDTH:0]      acc_sum;
    logic                            acc_ovf;
    logic [WIDE_WIDTH-1:0]           acc_sat;
    logic [STATE_WIDTH:0]            acc_clamp;
    logic signed [WIDE_WIDTH:0]      y_round;
    logic                            y_round_ovf;
    logic [WIDE_WIDTH-1:0]           y_round_sat;
    logic [OUT_SHIFT_WIDTH-1:0]      r_shift;
    logic                            r_ovf;
    logic [SAMPLE_WIDTH-1:0]         r_sat;
    logic                            step_sat;

    // Clamp a wide value to the state width; the top bit flags saturation.
    function automatic logic [STATE_WIDTH:0] clamp_state(input logic [WIDE_WIDTH-1:0] v);
        logic                   ovf;
        logic [STATE_WIDTH-1:0] r;
        ovf = (v[WIDE_WIDTH-1:STATE_WIDTH-1] != {(WIDE_WIDTH-STATE_WIDTH+1){v[WIDE_WIDTH-1]}});
        if (ovf)
        begin
            r = {v[WIDE_WIDTH-1], {(STATE_WIDTH-1){~v[WIDE_WIDTH-1]}}};
        end
        else
        begin
            r = v[STATE_WIDTH-1:0];
        end
        return {ovf, r};
    endfunction

    // Input sample moved to the internal fraction format.
    assign x_wide   = WIDE_WIDTH'(sample_reg) <<< FRAC_BITS;
    assign xq_clamp = clamp_state(x_wide);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.coef_sel)
            COEF_B0: coef_op = coef.b0;
            COEF_B1: coef_op = coef.b1;
            COEF_B2: coef_op = coef.b2;
            COEF_A1: coef_op = coef.a1;
            COEF_A2: coef_op = coef.a2;
            default: coef_op = coef.b0;
        endcase
        unique case (cmd.val_sel)
            VAL_XQ:  val_op = xq_clamp[STATE_WIDTH-1:0];
            VAL_D1:  val_op = d1_reg;
            VAL_D2:  val_op = d2_reg;
            VAL_OD1: val_op = od1_reg;
            VAL_OD2: val_op = od2_reg;
            VAL_Y:   val_op = y_reg;
            default: val_op = y_reg;
        endcase
    end

    // One 32-bit half of the value per pass: low half unsigned, high half signed.
    assign val_wide = WIDE_WIDTH'(val_op);
    assign mul_b    = cmd.mul_hi ? {val_wide[WIDE_WIDTH-1], val_wide[WIDE_WIDTH-1:CHUNK_WIDTH]}
                                 : {1'b0, val_wide[CHUNK_WIDTH-1:0]};
    assign mul_prod = coef_op * mul_b;

    // Join the halves, round half up and saturate the product to 64 bits.
    assign full_prod  = (FULL_WIDTH'(mul_reg) <<< CHUNK_WIDTH) + FULL_WIDTH'(lo_reg);
    assign prod_shift = full_prod[FULL_WIDTH-1:FRAC_BITS];
    assign term_ovf   = (prod_shift[SHIFTED_WIDTH-1:WIDE_WIDTH-1]
                         != {(SHIFTED_WIDTH-WIDE_WIDTH+1){prod_shift[SHIFTED_WIDTH-1]}});
    assign term_next  = term_ovf
        ? {prod_shift[SHIFTED_WIDTH-1], {(WIDE_WIDTH-1){~prod_shift[SHIFTED_WIDTH-1]}}}
        : prod_shift[WIDE_WIDTH-1:0];

    // Saturating accumulate of a product term or a delay word.
    always_comb
    begin
        case (cmd.acc_src)
            SRC_D1:  acc_opnd = WIDE_WIDTH'(d1_reg);
            SRC_D2:  acc_opnd = WIDE_WIDTH'(d2_reg);
            default: acc_opnd = term_reg;
        endcase
    end

    assign acc_sum = (cmd.acc_op == ACC_SUB)
                   ? ((WIDE_WIDTH + 1)'(acc_reg) - (WIDE_WIDTH + 1)'(acc_opnd))
                   : ((WIDE_WIDTH + 1)'(acc_reg) + (WIDE_WIDTH + 1)'(acc_opnd));
    assign acc_ovf = (acc_sum[WIDE_WIDTH] != acc_sum[WIDE_WIDTH-1]);
    assign acc_sat = acc_ovf ? {acc_sum[WIDE_WIDTH], {(WIDE_WIDTH-1){~acc_sum[WIDE_WIDTH]}}}
                             : acc_sum[WIDE_WIDTH-1:0];

    assign acc_clamp = clamp_state(acc_reg);

    // Output rounding: add one half, saturate, drop the fraction, clamp to a sample.
    assign y_round     = (WIDE_WIDTH + 1)'(y_reg) + $signed(ROUND_WIDE);
    assign y_round_ovf = (y_round[WIDE_WIDTH] != y_round[WIDE_WIDTH-1]);
    assign y_round_sat = y_round_ovf
        ? {y_round[WIDE_WIDTH], {(WIDE_WIDTH-1){~y_round[WIDE_WIDTH]}}}
        : y_round[WIDE_WIDTH-1:0];
    assign r_shift     = y_round_sat[WIDE_WIDTH-1:FRAC_BITS];
    assign r_ovf       = (r_shift[OUT_SHIFT_WIDTH-1:SAMPLE_WIDTH-1]
                          != {(OUT_SHIFT_WIDTH-SAMPLE_WIDTH+1){r_shift[OUT_SHIFT_WIDTH-1]}});
    assign r_sat       = r_ovf
        ? {r_shift[OUT_SHIFT_WIDTH-1], {(SAMPLE_WIDTH-1){~r_shift[OUT_SHIFT_WIDTH-1]}}}
        : r_shift[SAMPLE_WIDTH-1:0];

    // Saturation events of this cycle.
    assign step_sat = (mul_vld_reg && mul_hi_reg && term_ovf)
                    || (((cmd.acc_op == ACC_ADD) || (cmd.acc_op == ACC_SUB)) && acc_ovf)
                    || ((cmd.wr_sel != WR_NONE) && (cmd.wr_sel != WR_Y_SHIFT) && acc_clamp[STATE_WIDTH])
                    || ((cmd.wr_sel == WR_Y_SHIFT) && acc_clamp[STATE_WIDTH]);

    // Multiplier pipeline tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            mul_hi_reg  <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= cmd.mul_en;
            mul_hi_reg  <= cmd.mul_hi;
        end
    end

    // Input sample, product, rounding and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.mul_en)
        begin
            mul_reg <= mul_prod;
        end
        if (mul_vld_reg && !mul_hi_reg)
        begin
            lo_reg <= mul_reg + $signed(ROUND_PROD);
        end
        if (mul_vld_reg && mul_hi_reg)
        begin
            term_reg <= term_next;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= term_reg;
            ACC_ADD,
            ACC_SUB:  acc_reg <= acc_sat;
            default:  ;
        endcase
    end

    // Filter state and the sticky saturation flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg  <= '0;
            d2_reg  <= '0;
            od1_reg <= '0;
            od2_reg <= '0;
            y_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                sat_reg <= xq_clamp[STATE_WIDTH];
            end
            else if (step_sat)
            begin
                sat_reg <= 1'b1;
            end
            case (cmd.wr_sel)
                WR_Y:
                begin
                    y_reg   <= acc_clamp[STATE_WIDTH-1:0];
                    od1_reg <= acc_clamp[STATE_WIDTH-1:0];
                end
                WR_Y_SHIFT:
                begin
                    y_reg   <= acc_clamp[STATE_WIDTH-1:0];
                    od1_reg <= acc_clamp[STATE_WIDTH-1:0];
                    od2_reg <= od1_reg;
                    d1_reg  <= xq_clamp[STATE_WIDTH-1:0];
                    d2_reg  <= d1_reg;
                end
                WR_D1:   d1_reg <= acc_clamp[STATE_WIDTH-1:0];
                WR_D2:   d2_reg <= acc_clamp[STATE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.bypass)
            begin
                out_sample_reg <= sample_reg;
                out_clip_reg   <= 1'b0;
            end
            else
            begin
                out_sample_reg <= r_sat;
                out_clip_reg   <= sat_reg || y_round_ovf || r_ovf;
            end
        end
    end

    assign sample_out = out_sample_reg;
    assign clipped    = out_clip_reg;

endmodule

[hw/rtl/biquad_iir_filter.sv]
// Biquad section, direct form 1 or transposed direct form 2, one shared 33x32 multiplier.
// A new word is taken only after the last one has gone to the output register. The single
// multiplier sets the pace: each of the five products takes two passes.
// Reset (rst_n low, asynchronous) clears the four delay words, the control state and the
// registers to enable 0, transposed form, b0 = 1.0 and the other coefficients 0.
module biquad_iir_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_WIDTH-1:0]    sample_out,
    output logic                       clipped
);

    logic      enable_reg;
    logic      form_reg;
    coef_set_t coef_reg;
    dp_cmd_t   cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            form_reg    <= FORM_TF2;
            coef_reg.b0 <= COEF_ONE;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_FORM:    form_reg    <= cfg_data[0];
                CFG_COEF_B0: coef_reg.b0 <= cfg_data;
                CFG_COEF_B1: coef_reg.b1 <= cfg_data;
                CFG_COEF_B2: coef_reg.b2 <= cfg_data;
                CFG_COEF_A1: coef_reg.a1 <= cfg_data;
                CFG_COEF_A2: coef_reg.a2 <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer.
    biq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enable_reg),
        .form_select (form_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    // Arithmetic and state.
    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef_reg),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule
